>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level of the EDF ready queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, sampled on clk and switched off during rst.
`define EDFQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication, sampled on clk and switched off during rst.
`define EDFQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/edfq_pkg.sv
// Shared types, codes and default sizes of the EDF ready queue.
package edfq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  // Fixed field widths of the command and result beats.
  localparam int CMD_W    = 2;
  localparam int JOB_W    = 8;
  localparam int DL_W     = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_WRITE,
    FSM_PLACE
  } fsm_t;

  // Result of the shared deadline unit.
  typedef struct packed {
    logic            later;   // stored deadline is strictly later than the new one
    logic [DL_W-1:0] dec_dl;  // stored deadline lowered by one, held at zero
  } alu_res_t;

endpackage

>>> hw/rtl/edfq_cmp_unit.sv
// Shared deadline unit: ordering compare and saturating decrement.
module edfq_cmp_unit (
  input  logic [edfq_pkg::DL_W-1:0] slot_dl,
  input  logic [edfq_pkg::DL_W-1:0] new_dl,
  output edfq_pkg::alu_res_t        res
);
  import edfq_pkg::*;

  // The new job goes behind every entry whose deadline is equal or smaller.
  assign res.later = (slot_dl > new_dl);

  // A tick never takes a deadline below zero.
  assign res.dec_dl = (slot_dl == '0) ? slot_dl : slot_dl - DL_W'(1);

endmodule

>>> hw/rtl/edf_ready_queue_unit.sv
// Top level of the EDF ready queue: slot memory, sequencer and result register.
//
//   channel   | handshake           | fields
//   ----------+---------------------+---------------------------------------------
//   command   | start, busy         | cmd, job_id, deadline
//   result    | done (one cycle)    | status, preempt, head_valid, head_job,
//             |                     | head_deadline, job_count
//
// A command beat is taken when start is high and busy is low. Its result beat
// follows once the sequencer has walked N slots: every queued slot for a tick,
// occupancy - 1 for a pop, and for an insert the slots behind the new job plus
// the slot it stops behind (a final place step instead if it lands at the head).
// Each walked slot takes a read state and then a write state, as the slot memory
// has a registered read. Rejected and trivial commands finish straight from idle.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
// The receiver cannot stall: done is high for exactly one cycle per beat.
module edf_ready_queue_unit #(
  parameter int QUEUE_DEPTH = edfq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = edfq_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [edfq_pkg::CMD_W-1:0]    cmd,
  input  logic [edfq_pkg::JOB_W-1:0]    job_id,
  input  logic [edfq_pkg::DL_W-1:0]     deadline,
  output logic                          busy,
  output logic                          done,
  output logic [edfq_pkg::STATUS_W-1:0] status,
  output logic                          preempt,
  output logic                          head_valid,
  output logic [edfq_pkg::JOB_W-1:0]    head_job,
  output logic [edfq_pkg::DL_W-1:0]     head_deadline,
  output logic [edfq_pkg::COUNT_W-1:0]  job_count
);
  import edfq_pkg::*;

`include "assert_macros.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = ID_BITS + DL_W;

  // Slot memory, one entry holds {job id, remaining deadline}.
  logic [EW-1:0] mem [QUEUE_DEPTH];

  fsm_t               state, state_next;
  cmd_t               op;
  cmd_t               cmd_in;
  logic [ID_BITS-1:0] new_id;
  logic [DL_W-1:0]    new_dl;
  logic [AW-1:0]      idx, idx_next;
  logic [CW-1:0]      occ, occ_next;
  logic [EW-1:0]      rd_q;
  logic [ID_BITS-1:0] head_id_q;
  logic [DL_W-1:0]    head_dl_q;

  logic               accept;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [EW-1:0]      wr_data;
  logic [EW-1:0]      new_entry;
  logic               fin;
  status_t            fin_status;
  logic               fin_preempt;
  logic               last_tick;
  logic               last_pop;
  logic               wr_head;
  logic [ID_BITS-1:0] head_id_cur;
  logic [DL_W-1:0]    head_dl_cur;
  logic               head_valid_next;
  alu_res_t           alu;

  assign busy      = (state != FSM_IDLE);
  assign accept    = start && !busy;
  assign cmd_in    = cmd_t'(cmd);
  assign new_entry = {new_id, new_dl};

  // Walk end markers for tick and pop.
  assign last_tick = (CW'(idx) == occ - CW'(1));
  assign last_pop  = ((CW'(idx) + CW'(2)) == occ);

  // Shared compare and decrement unit works on the slot just read.
  edfq_cmp_unit u_cmp (
    .slot_dl (rd_q[DL_W-1:0]),
    .new_dl  (new_dl),
    .res     (alu)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_TICK: begin
              if (occ != '0) state_next = FSM_READ;
            end
            CMD_INSERT: begin
              if (occ == CW'(QUEUE_DEPTH)) state_next = FSM_IDLE;
              else if (occ == '0) state_next = FSM_PLACE;
              else state_next = FSM_READ;
            end
            CMD_POP: begin
              if (occ > CW'(1)) state_next = FSM_READ;
            end
            CMD_NONE: state_next = FSM_IDLE;
          endcase
        end
      end
      FSM_READ: state_next = FSM_WRITE;
      FSM_WRITE: begin
        unique case (op)
          CMD_TICK:   state_next = last_tick ? FSM_IDLE : FSM_READ;
          CMD_POP:    state_next = last_pop ? FSM_IDLE : FSM_READ;
          CMD_INSERT: begin
            if (!alu.later) state_next = FSM_IDLE;
            else if (idx == AW'(1)) state_next = FSM_PLACE;
            else state_next = FSM_READ;
          end
          CMD_NONE:   state_next = FSM_IDLE;
        endcase
      end
      FSM_PLACE: state_next = FSM_IDLE;
    endcase
  end

  // Memory controls, walk index, occupancy and result values per state.
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = idx;
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_data     = rd_q;
    idx_next    = idx;
    occ_next    = occ;
    fin         = 1'b0;
    fin_status  = STAT_OK;
    fin_preempt = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_TICK: begin
              idx_next = '0;
              if (occ == '0) fin = 1'b1;
            end
            CMD_INSERT: begin
              if (occ == CW'(QUEUE_DEPTH)) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else begin
                idx_next = occ[AW-1:0];
              end
            end
            CMD_POP: begin
              idx_next = '0;
              if (occ == '0) begin
                fin        = 1'b1;
                fin_status = STAT_EMPTY;
              end else if (occ == CW'(1)) begin
                fin      = 1'b1;
                occ_next = '0;
              end
            end
            CMD_NONE: fin = 1'b1;
          endcase
        end
      end
      FSM_READ: begin
        rd_en = 1'b1;
        unique case (op)
          CMD_TICK:   rd_addr = idx;
          CMD_POP:    rd_addr = idx + AW'(1);
          CMD_INSERT: rd_addr = idx - AW'(1);
          CMD_NONE:   rd_en   = 1'b0;
        endcase
      end
      FSM_WRITE: begin
        unique case (op)
          CMD_TICK: begin
            wr_en   = 1'b1;
            wr_data = {rd_q[EW-1:DL_W], alu.dec_dl};
            if (last_tick) fin = 1'b1;
            else idx_next = idx + AW'(1);
          end
          CMD_POP: begin
            wr_en   = 1'b1;
            wr_data = rd_q;
            if (last_pop) begin
              fin      = 1'b1;
              occ_next = occ - CW'(1);
            end else begin
              idx_next = idx + AW'(1);
            end
          end
          CMD_INSERT: begin
            wr_en = 1'b1;
            if (alu.later) begin
              // Shift the later entry one slot toward the tail.
              wr_data  = rd_q;
              idx_next = idx - AW'(1);
            end else begin
              wr_data  = new_entry;
              fin      = 1'b1;
              occ_next = occ + CW'(1);
            end
          end
          CMD_NONE: wr_en = 1'b0;
        endcase
      end
      FSM_PLACE: begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        wr_data     = new_entry;
        fin         = 1'b1;
        occ_next    = occ + CW'(1);
        fin_preempt = (occ != '0);
      end
    endcase
  end

  // The head copy follows every write to slot zero.
  assign wr_head         = wr_en && (wr_addr == '0);
  assign head_id_cur     = wr_head ? wr_data[EW-1:DL_W] : head_id_q;
  assign head_dl_cur     = wr_head ? wr_data[DL_W-1:0] : head_dl_q;
  assign head_valid_next = (occ_next != '0);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      occ   <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      idx   <= idx_next;
      done  <= fin;
    end
  end

  // Command beat capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= cmd_in;
      new_id <= ID_BITS'(job_id);
      new_dl <= deadline;
    end
  end

  // Slot memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Shadow of slot zero.
  always_ff @(posedge clk) begin
    if (wr_head) begin
      head_id_q <= wr_data[EW-1:DL_W];
      head_dl_q <= wr_data[DL_W-1:0];
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (fin) begin
      status        <= fin_status;
      preempt       <= fin_preempt;
      head_valid    <= head_valid_next;
      head_job      <= head_valid_next ? JOB_W'(head_id_cur) : '0;
      head_deadline <= head_valid_next ? head_dl_cur : '0;
      job_count     <= COUNT_W'(occ_next);
    end
  end

  // Checks on the sequencer and the result beat.
  `EDFQ_ASSERT(a_occ_bound, occ <= CW'(QUEUE_DEPTH), "occupancy above queue depth")
  `EDFQ_ASSERT_IMPL(a_done_idle, done, state == FSM_IDLE, "result beat while walking")
  `EDFQ_ASSERT_IMPL(a_head_occ, done, head_valid == (occ != '0), "head_valid disagrees with count")
  `EDFQ_ASSERT_IMPL(a_full_occ, done && (status == STAT_FULL), occ == CW'(QUEUE_DEPTH), "full status with free slot")
  `EDFQ_ASSERT_IMPL(a_preempt_ok, done && preempt, (status == STAT_OK) && head_valid && (occ > CW'(1)), "preempt without a displaced head")

endmodule

>>> sim/edf_ready_queue_unit_tb.sv
// Self-checking testbench for the EDF ready queue: command driver, queue predictor and checker.
`timescale 1ns / 1ps

module edf_ready_queue_unit_tb;
  import edfq_pkg::*;

  localparam int SLOTS       = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 650;

  // One result beat as the queue should report it.
  typedef struct {
    status_t          status;
    logic             preempt;
    logic             head_valid;
    logic [JOB_W-1:0] head_job;
    logic [DL_W-1:0]  head_dl;
    logic [COUNT_W-1:0] count;
  } head_report_t;

  // Mirror of the sorted job list, plus the reports still owed by the block.
  class edf_queue_tracker;
    logic [JOB_W-1:0] job_slot[SLOTS];
    logic [DL_W-1:0]  dl_slot[SLOTS];
    int unsigned      used;
    head_report_t     owed_reports[$];
    int unsigned      fails;

    function new();
      used  = 0;
      fails = 0;
    endfunction

    function int unsigned queued_jobs();
      return used;
    endfunction

    function int unsigned outstanding();
      return owed_reports.size();
    endfunction

    // Apply one accepted command to the mirror and queue the report it causes.
    function void note_command(cmd_t op, logic [JOB_W-1:0] id, logic [DL_W-1:0] dl);
      head_report_t rep;
      int unsigned  pos;
      int unsigned  i;
      rep.status  = STAT_OK;
      rep.preempt = 1'b0;
      case (op)
        CMD_TICK: begin
          // Deadlines count down and stop at zero.
          for (i = 0; i < used; i++)
            if (dl_slot[i] != '0) dl_slot[i] = dl_slot[i] - 1'b1;
        end
        CMD_INSERT: begin
          if (used >= SLOTS) begin
            rep.status = STAT_FULL;
          end else begin
            // The new job goes behind every entry due at the same time or earlier.
            pos = 0;
            while (pos < used && dl_slot[pos] <= dl) pos++;
            for (i = used; i > pos; i--) begin
              job_slot[i] = job_slot[i-1];
              dl_slot[i]  = dl_slot[i-1];
            end
            job_slot[pos] = id;
            dl_slot[pos]  = dl;
            if (pos == 0 && used > 0) rep.preempt = 1'b1;
            used++;
          end
        end
        CMD_POP: begin
          if (used == 0) begin
            rep.status = STAT_EMPTY;
          end else begin
            for (i = 0; i + 1 < used; i++) begin
              job_slot[i] = job_slot[i+1];
              dl_slot[i]  = dl_slot[i+1];
            end
            used--;
          end
        end
        default: ;
      endcase
      rep.head_valid = (used > 0);
      rep.head_job   = (used > 0) ? job_slot[0] : '0;
      rep.head_dl    = (used > 0) ? dl_slot[0] : '0;
      rep.count      = used[COUNT_W-1:0];
      owed_reports.push_back(rep);
    endfunction

    function void compare_field(string field, logic [DL_W-1:0] want, logic [DL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        fails++;
      end
    endfunction

    // Compare a result beat with the oldest report still owed.
    function void check_result(logic [STATUS_W-1:0] st, logic pre, logic hv,
                               logic [JOB_W-1:0] hj, logic [DL_W-1:0] hd,
                               logic [COUNT_W-1:0] cnt);
      head_report_t want;
      if (owed_reports.size() == 0) begin
        $error("result beat with no command outstanding");
        fails++;
        return;
      end
      want = owed_reports.pop_front();
      compare_field("status", want.status, st);
      compare_field("preempt", want.preempt, pre);
      compare_field("head_valid", want.head_valid, hv);
      compare_field("head_job", want.head_job, hj);
      compare_field("head_deadline", want.head_dl, hd);
      compare_field("job_count", want.count, cnt);
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [CMD_W-1:0]   cmd = CMD_TICK;
  logic [JOB_W-1:0]   job_id = '0;
  logic [DL_W-1:0]    deadline = '0;
  logic               busy;
  logic               done;
  logic [STATUS_W-1:0] status;
  logic               preempt;
  logic               head_valid;
  logic [JOB_W-1:0]   head_job;
  logic [DL_W-1:0]    head_deadline;
  logic [COUNT_W-1:0] job_count;

  edf_queue_tracker tracker = new();
  int unsigned      cycle_count = 0;
  int unsigned      idle_pct = 23;
  bit               filling = 1'b1;

  edf_ready_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .job_id       (job_id),
    .deadline     (deadline),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .preempt      (preempt),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .head_deadline(head_deadline),
    .job_count    (job_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL edf_ready_queue_unit");
      $finish;
    end
  end

  // Every result beat is checked at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_result(status, preempt, head_valid, head_job, head_deadline, job_count);
  end

  // Present one command beat and hold it until the block takes it.
  task automatic send_cmd(cmd_t op, logic [JOB_W-1:0] id, logic [DL_W-1:0] dl);
    @(negedge clk);
    start    <= 1'b1;
    cmd      <= op;
    job_id   <= id;
    deadline <= dl;
    do @(posedge clk); while (busy);
    tracker.note_command(op, id, dl);
  endtask

  // Random sender gap: each cycle idles with the current probability.
  task automatic sender_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic hold_until_drained();
    do begin
      @(negedge clk);
      start <= 1'b0;
    end while (tracker.outstanding() != 0);
  endtask

  // Mostly short deadlines so that ties and zero saturation come up often.
  function automatic logic [DL_W-1:0] pick_deadline();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 16'd1;
          2: return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      1, 2: return DL_W'($urandom_range(0, 65535));
      default: return DL_W'($urandom_range(0, 12));
    endcase
  endfunction

  // Fill and drain runs keep the queue swinging between empty and full.
  task automatic send_random();
    int unsigned roll;
    cmd_t        op;
    if (tracker.queued_jobs() >= SLOTS && $urandom_range(0, 1)) filling = 1'b0;
    if (tracker.queued_jobs() == 0 && $urandom_range(0, 1)) filling = 1'b1;
    if ($urandom_range(0, 49) == 0) filling = !filling;
    roll = $urandom_range(0, 99);
    if (filling)
      op = (roll < 55) ? CMD_INSERT : (roll < 75) ? CMD_TICK : (roll < 94) ? CMD_POP : CMD_NONE;
    else
      op = (roll < 15) ? CMD_INSERT : (roll < 35) ? CMD_TICK : (roll < 95) ? CMD_POP : CMD_NONE;
    send_cmd(op, JOB_W'($urandom_range(0, 255)), pick_deadline());
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed beats: empty queue cases, ordering, preemption and saturation.
    idle_pct = 23;
    send_cmd(CMD_POP, 8'h00, 16'h0000);
    send_cmd(CMD_TICK, 8'h00, 16'h0000);
    send_cmd(CMD_NONE, 8'hFF, 16'hFFFF);
    send_cmd(CMD_INSERT, 8'h01, 16'd100);
    send_cmd(CMD_INSERT, 8'h02, 16'd50);
    send_cmd(CMD_INSERT, 8'h03, 16'd50);
    send_cmd(CMD_INSERT, 8'h00, 16'd0);
    send_cmd(CMD_TICK, 8'h00, 16'h0000);
    send_cmd(CMD_TICK, 8'hFF, 16'hFFFF);
    send_cmd(CMD_INSERT, 8'hFF, 16'hFFFF);
    send_cmd(CMD_INSERT, 8'hA5, 16'h8000);
    send_cmd(CMD_NONE, 8'h00, 16'h0000);
    send_cmd(CMD_POP, 8'h00, 16'h0000);
    while (tracker.queued_jobs() < SLOTS) begin
      sender_gap();
      send_cmd(CMD_INSERT, JOB_W'($urandom_range(0, 255)), pick_deadline());
    end
    // A rejected insert must not flag preemption even with the earliest deadline.
    send_cmd(CMD_INSERT, 8'h5A, 16'h0000);
    hold_until_drained();

    // Random beats in three idling phases, with a full drain between phases.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 70 : 0;
      repeat (PHASE_ITEMS) begin
        sender_gap();
        send_random();
        if ($urandom_range(0, 199) == 0) hold_until_drained();
      end
      hold_until_drained();
    end

    // Let any stray beat show up before the verdict.
    repeat (2 * SLOTS + 8) @(negedge clk);
    if (tracker.fails == 0 && tracker.outstanding() == 0)
      $display("PASS edf_ready_queue_unit");
    else
      $display("FAIL edf_ready_queue_unit");
    $finish;
  end

endmodule
